/* design/mspo_pkg.sv */
`default_nettype none
package mspo_pkg;

    localparam int PHASE_BITS = 24;
    localparam int CFG_DATA_BITS = 24;
    localparam int CFG_INDEX_BITS = 3;

    // register indexes on the configuration port
    localparam logic [CFG_INDEX_BITS-1:0] REG_MODE      = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_AMOUNT    = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_INCREMENT = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_NOTE      = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SEED      = 3'd4;

    localparam logic [15:0] LFSR_TAPS = 16'hb400;
    localparam logic [6:0]  NOTE_LIMIT = 7'd107;
    localparam logic [7:0]  HALF_LEVEL = 8'd127;
    localparam logic [7:0]  PULSE_STEP = 8'd63;

    typedef enum logic [2:0] {
        MODE_TRIANGLE   = 3'd0,
        MODE_PULSE      = 3'd1,
        MODE_QUAD_SAW   = 3'd2,
        MODE_QUAD_PULSE = 3'd3,
        MODE_NOISE      = 3'd4,
        MODE_SAW        = 3'd5,
        MODE_PWM        = 3'd6,
        MODE_CSAW       = 3'd7
    } mode_t;

    typedef struct packed {
        mode_t                 mode;
        logic [6:0]            amount;
        logic [PHASE_BITS-1:0] increment;
        logic [6:0]            note;
        logic [15:0]           seed;
    } cfg_t;

    typedef struct packed {
        logic [7:0] sample;
        logic       wrapped;
    } res_t;

endpackage
`default_nettype wire

/* design/multi_shape_phase_oscillator.sv */
`default_nettype none
// Phase-accumulator oscillator with hard sync: one 8-bit sample and a sync-out
// flag per input item. Each item is computed combinationally from the
// oscillator state and registered in a two-entry output buffer; a new item
// can be taken every cycle while in_stall is low; in_stall rises only when the
// buffer holds two items. Modes 5..7 return the sample of the previous item.
// Configuration writes take effect for the next item and should be made only
// while no item is in flight.
module multi_shape_phase_oscillator (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write,
    input  wire logic [mspo_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [mspo_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic                                sync_in,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic [7:0]                               sample,
    output logic                                     wrapped
);
    import mspo_pkg::*;

    cfg_t cfg;
    res_t res;
    res_t out_res;
    logic accept;
    logic full;

    assign in_stall = full;
    assign accept   = in_valid && !full;

    mspo_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    mspo_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .sync_in (sync_in),
        .cfg     (cfg),
        .res     (res)
    );

    mspo_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .res       (res),
        .full      (full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    assign sample  = out_res.sample;
    assign wrapped = out_res.wrapped;

endmodule
`default_nettype wire

/* design/mspo_cfg.sv */
`default_nettype none
module mspo_cfg (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_write,
    input  wire logic [mspo_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [mspo_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output mspo_pkg::cfg_t                           cfg
);
    import mspo_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_MODE:      cfg_next.mode = mode_t'(cfg_data[2:0]);
                REG_AMOUNT:    cfg_next.amount = cfg_data[6:0];
                REG_INCREMENT: cfg_next.increment = cfg_data[PHASE_BITS-1:0];
                REG_NOTE:      cfg_next.note = cfg_data[6:0];
                REG_SEED:      cfg_next.seed = cfg_data[15:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode      <= MODE_TRIANGLE;
            cfg_reg.amount    <= '0;
            cfg_reg.increment <= '0;
            cfg_reg.note      <= '0;
            cfg_reg.seed      <= 16'd1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule
`default_nettype wire

/* design/mspo_core.sv */
`default_nettype none
module mspo_core (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     accept,
    input  wire logic     sync_in,
    input  mspo_pkg::cfg_t cfg,
    output mspo_pkg::res_t res
);
    import mspo_pkg::*;

    logic [PHASE_BITS-1:0] phase_reg, phase_next;
    logic [15:0]           det_reg [3];
    logic [15:0]           det_next [3];
    logic [15:0]           lfsr_reg, lfsr_next;
    logic [7:0]            lp_reg, lp_next;
    logic [7:0]            delayed_reg, delayed_next;

    logic [PHASE_BITS-1:0] adv_phase;
    logic                  adv_sync;
    logic [15:0]           top16;
    logic [7:0]            top8;
    logic [7:0]            pw;
    logic [7:0]            amt2;
    logic [7:0]            ramp;
    logic [7:0]            tri_v;
    logic [15:0]           base;
    logic [22:0]           spread_prod;
    logic [15:0]           spread;
    logic [15:0]           step [3];
    logic [15:0]           det_new [3];
    logic [7:0]            quad_saw;
    logic [7:0]            quad_pulse;
    logic [7:0]            k;
    logic [15:0]           lfsr_fixed;
    logic [15:0]           lfsr_loaded;
    logic [15:0]           lfsr_shifted;
    logic [7:0]            n;
    logic [15:0]           lp_sum;
    logic [7:0]            lp_new;
    logic [7:0]            noise_v;
    logic [7:0]            naive_next;
    logic [7:0]            sample_v;
    logic                  sync_v;

    // phase update and wrap flag
    always_comb
    begin
        if (sync_in)
        begin
            adv_phase = cfg.increment;
        end
        else
        begin
            adv_phase = phase_reg + cfg.increment;
        end
        adv_sync = sync_in || (adv_phase <= cfg.increment);
        top16 = adv_phase[PHASE_BITS-1 -: 16];
        top8  = adv_phase[PHASE_BITS-1 -: 8];
    end

    assign pw   = HALF_LEVEL + {1'b0, cfg.amount};
    assign amt2 = {cfg.amount, 1'b0};

    // folded triangle
    always_comb
    begin
        ramp = top16[14:7];
        if (top16[15])
        begin
            tri_v = ramp;
        end
        else
        begin
            tri_v = ~ramp;
        end
        if (tri_v < {1'b0, cfg.amount})
        begin
            tri_v = amt2 - tri_v;
        end
    end

    // detuned voices
    always_comb
    begin
        base        = cfg.increment[PHASE_BITS-1 -: 16];
        spread_prod = base * {16'd0, cfg.amount};
        spread      = {6'd0, spread_prod[22:13]} + 16'd1;
        step[0]     = base + spread;
        step[1]     = step[0] + spread;
        step[2]     = step[1] + spread;
        for (int i = 0; i < 3; i++)
        begin
            det_new[i] = det_reg[i] + step[i];
        end
        quad_saw = {2'b00, top16[15:10]} + {2'b00, det_new[0][15:10]}
                 + {2'b00, det_new[1][15:10]} + {2'b00, det_new[2][15:10]};
        quad_pulse = (top16 < {pw, 8'h00}) ? 8'd0 : PULSE_STEP;
        for (int i = 0; i < 3; i++)
        begin
            if (det_new[i][15:8] >= pw)
            begin
                quad_pulse = quad_pulse + PULSE_STEP;
            end
        end
    end

    // filtered noise
    always_comb
    begin
        k = {cfg.amount[5:0], 2'b00};
        if (k <= 8'd4)
        begin
            k = 8'd4;
        end
        lfsr_fixed  = (lfsr_reg == 16'd0) ? 16'd1 : lfsr_reg;
        lfsr_loaded = sync_in ? cfg.seed : lfsr_fixed;
        lfsr_shifted = {1'b0, lfsr_loaded[15:1]} ^ (lfsr_loaded[0] ? LFSR_TAPS : 16'd0);
        n = lfsr_shifted[15:8];
        lp_sum = 16'(lp_reg) * 16'(8'd255 - k) + 16'(n) * 16'(k);
        lp_new = lp_sum[15:8];
        if (cfg.amount[6])
        begin
            noise_v = lp_new + HALF_LEVEL - n;
        end
        else
        begin
            noise_v = lp_new + amt2;
        end
    end

    // naive shapes, stored for output on the following item
    always_comb
    begin
        if (cfg.note > NOTE_LIMIT)
        begin
            naive_next = top8;
        end
        else
        begin
            case (cfg.mode)
                MODE_SAW:
                    naive_next = (top8 >= HALF_LEVEL) ? top8 - {1'b0, cfg.amount} : top8;
                MODE_PWM:
                    naive_next = (top8 >= pw) ? 8'hff : 8'h00;
                default:
                    naive_next = (top8 >= {1'b0, cfg.amount}) ? top8 : 8'h00;
            endcase
        end
    end

    // result select and state update
    always_comb
    begin
        phase_next   = phase_reg;
        lfsr_next    = lfsr_reg;
        lp_next      = lp_reg;
        delayed_next = delayed_reg;
        for (int i = 0; i < 3; i++)
        begin
            det_next[i] = det_reg[i];
        end
        sync_v = adv_sync;
        case (cfg.mode)
            MODE_TRIANGLE:
                sample_v = tri_v;
            MODE_PULSE:
                sample_v = (top8 < pw) ? 8'h00 : 8'hff;
            MODE_QUAD_SAW,
            MODE_QUAD_PULSE:
            begin
                sample_v = (cfg.mode == MODE_QUAD_SAW) ? quad_saw : quad_pulse;
                for (int i = 0; i < 3; i++)
                begin
                    det_next[i] = det_new[i];
                end
            end
            MODE_NOISE:
            begin
                sample_v  = noise_v;
                sync_v    = 1'b0;
                lfsr_next = lfsr_shifted;
                lp_next   = lp_new;
            end
            default:
            begin
                sample_v     = delayed_reg;
                delayed_next = naive_next;
            end
        endcase
        if (cfg.mode != MODE_NOISE)
        begin
            phase_next = adv_phase;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= '0;
            lfsr_reg    <= 16'd1;
            lp_reg      <= '0;
            delayed_reg <= '0;
            for (int i = 0; i < 3; i++)
            begin
                det_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            lfsr_reg    <= lfsr_next;
            lp_reg      <= lp_next;
            delayed_reg <= delayed_next;
            for (int i = 0; i < 3; i++)
            begin
                det_reg[i] <= det_next[i];
            end
        end
    end

    assign res.sample  = sample_v;
    assign res.wrapped = sync_v;

endmodule
`default_nettype wire

/* design/mspo_out.sv */
`default_nettype none
module mspo_out (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     load,
    input  mspo_pkg::res_t res,
    output logic          full,
    output logic          out_valid,
    input  wire logic     out_stall,
    output mspo_pkg::res_t out_res
);
    import mspo_pkg::*;

    res_t out_reg;
    res_t skid_reg;
    logic out_valid_reg, out_valid_next;
    logic skid_valid_reg, skid_valid_next;
    logic take;

    assign take = out_valid_reg && !out_stall;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || take)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = load;
            end
        end
        else if (load)
        begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload: output stage refills from the skid item first
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || take)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (load)
            begin
                out_reg <= res;
            end
        end
        else if (load)
        begin
            skid_reg <= res;
        end
    end

    assign full      = skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

endmodule
`default_nettype wire
